>>> design/lzwe_pkg.sv
// Shared types and constants for the LZW byte stream encoder.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package lzwe_pkg;

    localparam int CODE_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 13;
    localparam int ENTRY_W    = CODE_W + BYTE_W;
    localparam logic [COUNT_W-1:0] BASE_CODES = 13'd256;
    localparam logic [COUNT_W-1:0] CODE_SPACE = 13'd4096;
    localparam logic [COUNT_W-1:0] MAX_RESET  = 13'd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_COMPARE,
        ST_MISS,
        ST_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // take the input transaction
        logic start_match;  // first byte of a message becomes the match
        logic scan_init;    // point the scan at the first learned code
        logic scan_inc;     // step to the next learned code
        logic rd_en;        // read the entry under the scan pointer
        logic hit_take;     // the scanned entry becomes the match
        logic miss_do;      // emit the match, learn the string unless full, restart
        logic flush_do;     // emit the final code and clear the dictionary
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic match_valid;
        logic scan_done;
        logic hit;
        logic out_busy;
        logic last;
    } status_t;

endpackage
`default_nettype wire

>>> design/lzwe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> design/lzwe_ctrl.sv
// Sequencing state machine of the LZW encoder.
// Depends on lzwe_pkg; drives the datapath through cmd_t, watches status_t.
`default_nettype none
module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = status.match_valid ? ST_READ : ST_FLUSH;
            end
            ST_READ:
            begin
                state_next = status.scan_done ? ST_MISS : ST_COMPARE;
            end
            ST_COMPARE:
            begin
                state_next = status.hit ? ST_FLUSH : ST_READ;
            end
            ST_MISS:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.last || !status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_fire;
            end
            ST_DECIDE:
            begin
                cmd.start_match = !status.match_valid;
                cmd.scan_init   = status.match_valid;
            end
            ST_READ:
            begin
                cmd.rd_en = !status.scan_done;
            end
            ST_COMPARE:
            begin
                cmd.hit_take = status.hit;
                cmd.scan_inc = !status.hit;
            end
            ST_MISS:
            begin
                cmd.miss_do = !status.out_busy;
            end
            ST_FLUSH:
            begin
                cmd.flush_do = status.last && !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/lzwe_dp.sv
// Datapath of the LZW encoder: match state, dictionary scan, output register.
// Depends on lzwe_pkg and lzwe_ram.
`default_nettype none
module lzwe_dp
    import lzwe_pkg::*;
#(
    parameter int DICT_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic [BYTE_W-1:0]   in_byte,
    input  wire logic                in_last,
    input  wire logic                cfg_wr_en,
    input  wire logic [COUNT_W-1:0]  cfg_wr_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CODE_W-1:0]        out_code,
    output logic                     out_eom,
    output logic                     out_full
);

    localparam int AW = $clog2(DICT_DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_CAP =
        (DICT_DEPTH > 4096) ? CODE_SPACE : COUNT_W'(DICT_DEPTH);

    logic [COUNT_W-1:0] max_entries_reg;
    logic [COUNT_W-1:0] next_free_reg;
    logic [CODE_W-1:0]  match_code_reg;
    logic               match_valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic [COUNT_W-1:0] scan_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_eom_reg;
    logic               out_full_reg;

    logic [COUNT_W-1:0] limit;
    logic               full;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;

    assign limit  = (max_entries_reg < DEPTH_CAP) ? max_entries_reg : DEPTH_CAP;
    assign full   = next_free_reg >= limit;
    assign wr_en  = cmd.miss_do && !full;

    lzwe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(next_free_reg)),
        .wr_data ({match_code_reg, byte_reg}),
        .rd_en   (cmd.rd_en),
        .rd_addr (AW'(scan_reg)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        status.match_valid = match_valid_reg;
        status.scan_done   = (scan_reg >= next_free_reg) || (scan_reg >= DEPTH_CAP);
        status.hit         = (rd_data == {match_code_reg, byte_reg});
        status.out_busy    = out_valid_reg;
        status.last        = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.scan_init)
        begin
            scan_reg <= BASE_CODES;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + COUNT_W'(1);
        end
        if (cmd.miss_do)
        begin
            out_code_reg <= match_code_reg;
            out_eom_reg  <= 1'b0;
            out_full_reg <= full;
        end
        else if (cmd.flush_do)
        begin
            out_code_reg <= match_code_reg;
            out_eom_reg  <= 1'b1;
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_RESET;
            next_free_reg   <= BASE_CODES;
            match_code_reg  <= '0;
            match_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_entries_reg <= cfg_wr_data;
            end
            if (cmd.start_match)
            begin
                match_code_reg  <= CODE_W'(byte_reg);
                match_valid_reg <= 1'b1;
            end
            else if (cmd.hit_take)
            begin
                match_code_reg <= scan_reg[CODE_W-1:0];
            end
            else if (cmd.miss_do)
            begin
                match_code_reg <= CODE_W'(byte_reg);
            end
            if (wr_en)
            begin
                next_free_reg <= next_free_reg + COUNT_W'(1);
            end
            if (cmd.flush_do)
            begin
                next_free_reg   <= BASE_CODES;
                match_code_reg  <= '0;
                match_valid_reg <= 1'b0;
            end
            if (cmd.miss_do || cmd.flush_do)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_eom   = out_eom_reg;
    assign out_full  = out_full_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= DEPTH_CAP || next_free_reg == BASE_CODES)
        else $error("next free code beyond dictionary");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.miss_do || cmd.flush_do) |-> !out_valid_reg)
        else $error("result loaded over a pending one");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_do |=> (next_free_reg == BASE_CODES && !match_valid_reg))
        else $error("dictionary not cleared after flush");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (next_free_reg >= BASE_CODES && next_free_reg < DEPTH_CAP))
        else $error("dictionary write out of range");

endmodule
`default_nettype wire

>>> design/lzw_byte_stream_encoder.sv
// Top level of the LZW byte stream encoder: stream ports and config register.
// Depends on lzwe_pkg, lzwe_ctrl, lzwe_dp (which holds lzwe_ram).
//
// One byte enters per input transaction (tlast marks the final byte of a
// message) and the block emits LZW codes, at most two per byte: the code
// of the longest match on a dictionary miss, then on the last byte the
// remaining match with tlast set. The dictionary lives in one RAM of
// {prefix, byte} entries and is searched linearly from code 256 up to the
// next free code; each entry is read, then compared against the registered
// read data. A byte that starts a message is not scanned; otherwise the scan
// stops at the first matching entry, and a miss scans all N learned entries
// (N up to next_free_code - 256). A miss or flush also waits for the output
// register to be free. The block takes one byte at a time. The dictionary
// is reset to the 256 base codes after each message and needs no clearing
// pass. cfg_wr_data sets how many codes may be in use; when reached, no
// entries are learned and tuser flags the emitted code.
`default_nettype none
module lzw_byte_stream_encoder
    import lzwe_pkg::*;
#(
    parameter int DICT_DEPTH = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // last_byte
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [11:0] out_code, [15:12] zero
    output logic              m_axis_tlast,   // end_of_message
    output logic              m_axis_tuser,   // dict_full
    // configuration: max_entries
    input  wire logic         cfg_wr_en,
    input  wire logic [12:0]  cfg_wr_data
);

    cmd_t        cmd;
    status_t     status;
    logic        in_fire;
    logic [11:0] code;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    lzwe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    lzwe_dp #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_code    (code),
        .out_eom     (m_axis_tlast),
        .out_full    (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, code};

endmodule
`default_nettype wire

>>> sim/tb_lzw_byte_stream_encoder.sv
// Testbench for the LZW byte stream encoder: directed and random messages,
// predicted codes checked against the output stream, several max_entries values.
// Depends on the design under design/.
`default_nettype none
module tb_lzw_byte_stream_encoder;

    typedef struct packed {
        logic [11:0] code;
        logic        eom;
        logic        full;
    } code_txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = 13'd0;

    lzw_byte_stream_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #2 clk = ~clk;

    // Encoder shadow: dictionary, current match and the limit register.
    logic [11:0] dict_prefix [0:4095];
    logic [7:0]  dict_byte [0:4095];
    int unsigned free_code;
    logic [11:0] cur_match;
    logic        have_match;
    logic [12:0] entry_limit;

    code_txn_t   pending_codes[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    function automatic void clear_dict();
        free_code  = 256;
        cur_match  = '0;
        have_match = 1'b0;
    endfunction

    function automatic void queue_code(logic [11:0] c, logic eom, logic full);
        code_txn_t t;
        t = '{c, eom, full};
        pending_codes.insert(pending_codes.size(), t);
    endfunction

    // Predicts the codes produced by one byte and queues them.
    function automatic void encode_byte(logic [7:0] b, logic last);
        int unsigned hit;
        int unsigned lim;
        bit          full;
        hit = 0;
        if (!have_match)
        begin
            cur_match  = {4'd0, b};
            have_match = 1'b1;
        end
        else
        begin
            for (int unsigned k = 256; k < free_code && k < 4096; k++)
                if (hit == 0 && dict_prefix[k] == cur_match && dict_byte[k] == b)
                    hit = k;
            if (hit != 0)
                cur_match = hit[11:0];
            else
            begin
                lim  = (entry_limit > 4096) ? 4096 : entry_limit;
                full = free_code >= lim;
                queue_code(cur_match, 1'b0, full);
                if (!full)
                begin
                    dict_prefix[free_code] = cur_match;
                    dict_byte[free_code]   = b;
                    free_code++;
                end
                cur_match = {4'd0, b};
            end
        end
        if (last)
        begin
            queue_code(cur_match, 1'b1, 1'b0);
            clear_dict();
        end
    endfunction

    // Sends one byte transaction, with random gaps before it while idle_on is set.
    task automatic send_byte(logic [7:0] b, logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        encode_byte(b, last);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(logic [12:0] v);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        entry_limit = v;
    endtask

    task automatic send_message(int len, int alpha);
        for (int i = 0; i < len; i++)
            send_byte(alpha == 0 ? 8'($urandom) : 8'($urandom_range(0, alpha)),
                      i == len - 1);
    endtask

    // Output side: random stall bursts while idle_on is set, field-by-field check of each code.
    always @(posedge clk)
    begin
        code_txn_t expv;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected code %0d", m_axis_tdata[11:0]);
                end
                else
                begin
                    expv = pending_codes.pop_front();
                    if (m_axis_tdata != {4'd0, expv.code} || m_axis_tlast != expv.eom
                        || m_axis_tuser != expv.full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("code mismatch exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     expv.code, expv.eom, expv.full, m_axis_tdata,
                                     m_axis_tlast, m_axis_tuser);
                    end
                end
            end
            if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_byte(8'h00, 1'b1);              // one-byte message
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 8; i++)          // repeats build long matches
            send_byte(8'hAA, i == 7);
        send_byte(8'h55, 1'b0);              // miss and flush on the last byte
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_random_messages(int n_msgs);
        for (int m = 0; m < n_msgs; m++)
            send_message($urandom_range(1, 30), $urandom_range(0, 1) ? 3 : 0);
    endtask

    // Small limits so that the full flag is hit, plus one above the code space.
    task automatic test_limits();
        write_limit(13'd257);
        send_message(20, 2);
        write_limit(13'd0);
        send_message(12, 1);
        write_limit(13'd8191);
        send_message(20, 3);
        write_limit(13'd270);
        test_random_messages(10);
    endtask

    task automatic test_no_idling();
        wait_drain();
        idle_on = 1'b0;
        write_limit(13'd4096);
        test_random_messages(10);
    endtask

    initial
    begin
        entry_limit = 13'd4096;
        clear_dict();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_messages(30);
        test_limits();
        test_no_idling();
        wait_drain();
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
